// ===== sv/tlbw_pkg.sv =====
// Shared types and constants for the two-level page walk MMU.
// No dependencies; imported by every module of the block but tlbw_ram.
`timescale 1ns / 1ps
package tlbw_pkg;
	localparam int TLB_DEPTH_DEF   = 16;
	localparam int OUTER_W_DEF     = 10;
	localparam int INNER_W_DEF     = 10;
	localparam int PAGE_OFFSET_DEF = 12;
	localparam int FRAME_W         = 20;
	localparam int ADDR_W          = 32;
	localparam int CNT_W           = 32;

	localparam logic ACT_TRANSLATE = 1'b0;
	localparam logic ACT_MAP       = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOK
	} state_t;

	// Update command broadcast to every TLB cell.
	typedef struct packed {
		logic upd_hit;
		logic upd_fill;
		logic any_free;
	} cell_ctl_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] v,
			input logic [1:0] inc);
		logic [CNT_W:0] s;
		s = {1'b0, v} + {{(CNT_W-1){1'b0}}, inc};
		return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
	endfunction
endpackage

// ===== sv/tlbw_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module tlbw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== sv/tlbw_cell.sv =====
// One TLB entry cell: tag, frame, valid and LRU age; passes match and
// free-slot search along the chain. Depends on tlbw_pkg.
`timescale 1ns / 1ps
module tlbw_cell import tlbw_pkg::*; #(
	parameter int VPN_W = 20,
	parameter int AGE_W = 4,
	parameter int DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cell_ctl_t          ctl,
	input  logic [VPN_W-1:0]   vpn,
	input  logic [FRAME_W-1:0] fill_frame,
	input  logic [AGE_W-1:0]   ref_age,
	input  logic               match_in,
	input  logic [FRAME_W-1:0] frame_in,
	input  logic [AGE_W-1:0]   age_in,
	input  logic               free_in,
	output logic               match_out,
	output logic [FRAME_W-1:0] frame_out,
	output logic [AGE_W-1:0]   age_out,
	output logic               free_out
);
	localparam logic [AGE_W-1:0] OLDEST = AGE_W'(DEPTH - 1);

	logic               valid_q;
	logic [VPN_W-1:0]   page_q;
	logic [FRAME_W-1:0] frame_q;
	logic [AGE_W-1:0]   age_q;
	logic               hit_sel, victim, target;

	assign hit_sel   = valid_q && (page_q == vpn) && !match_in;
	assign match_out = match_in || hit_sel;
	assign frame_out = hit_sel ? frame_q : frame_in;
	assign age_out   = hit_sel ? age_q : age_in;
	assign free_out  = free_in || !valid_q;
	// first invalid slot, else the oldest entry when the table is full
	assign victim    = ctl.any_free ? (!valid_q && !free_in) : (age_q == OLDEST);
	assign target    = (ctl.upd_hit && hit_sel) || (ctl.upd_fill && victim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (ctl.upd_hit || ctl.upd_fill) begin
			if (target) begin
				age_q <= '0;
				if (ctl.upd_fill) begin
					valid_q <= 1'b1;
				end
			end else if (valid_q && age_q < ref_age) begin
				age_q <= age_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.upd_fill && target) begin
			page_q  <= vpn;
			frame_q <= fill_frame;
		end
	end
endmodule

// ===== sv/tlb_two_level_page_walk.sv =====
// Two-level page walk MMU with a fully associative true-LRU TLB.
// Result valid follows the input transfer through the lookup state and the result register; one item at a time,
// so a new item is accepted only once the previous result has been taken.
// The TLB compare and both table checks happen in the lookup cycle, on the
// registered memory read data. After reset a clearing pass wipes all 2**(outer+inner)
// page table entries (1048576 at defaults); in_ready stays low.
`timescale 1ns / 1ps
module tlb_two_level_page_walk import tlbw_pkg::*; #(
	parameter int TLB_DEPTH         = TLB_DEPTH_DEF,
	parameter int OUTER_INDEX_WIDTH = OUTER_W_DEF,
	parameter int INNER_INDEX_WIDTH = INNER_W_DEF,
	parameter int PAGE_OFFSET_WIDTH = PAGE_OFFSET_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               action,
	input  logic [ADDR_W-1:0]  virtual_address,
	input  logic [FRAME_W-1:0] map_frame,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [ADDR_W-1:0]  physical_address,
	output logic               xlat_fault,
	output logic               tlb_hit,
	output logic [CNT_W-1:0]   hit_count,
	output logic [CNT_W-1:0]   miss_count,
	output logic [CNT_W-1:0]   walk_access_count
);
	localparam int VPN_W   = OUTER_INDEX_WIDTH + INNER_INDEX_WIDTH;
	localparam int AGE_W   = $clog2(TLB_DEPTH);
	localparam int PAGES   = 1 << VPN_W;
	localparam int OUTERS  = 1 << OUTER_INDEX_WIDTH;
	localparam int PO      = PAGE_OFFSET_WIDTH;

	state_t state_q, state_d;

	logic                   accept;
	logic                   action_q;
	logic [VPN_W-1:0]       vpn_q;
	logic [PO-1:0]          offset_q;
	logic [FRAME_W-1:0]     mframe_q;
	logic [VPN_W-1:0]       clr_q;
	logic                   clr_last;

	// page table memories
	logic                   pg_we, out_we;
	logic [VPN_W-1:0]       pg_waddr;
	logic [FRAME_W:0]       pg_wdata, pg_rdata;
	logic [OUTER_INDEX_WIDTH-1:0] out_waddr;
	logic                   out_wdata, out_rdata;

	// cell chain
	cell_ctl_t              ctl;
	logic [TLB_DEPTH:0]     match_c, free_c;
	logic [FRAME_W-1:0]     frame_c [TLB_DEPTH+1];
	logic [AGE_W-1:0]       age_c   [TLB_DEPTH+1];
	logic [AGE_W-1:0]       ref_age;

	logic                   do_look, is_hit, walk_ok;
	logic [1:0]             walk_inc;

	assign accept   = in_valid && in_ready;
	assign clr_last = &clr_q;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_last) state_d = ST_IDLE;
			ST_IDLE:  if (accept) state_d = ST_LOOK;
			ST_LOOK:  state_d = ST_IDLE;
			default:  state_d = ST_CLEAR;
		endcase
	end

	// Outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		do_look  = 1'b0;
		case (state_q)
			ST_IDLE: in_ready = !out_valid;
			ST_LOOK: do_look  = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// Hold the item for the lookup cycle.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_q <= action;
			vpn_q    <= virtual_address[PO +: VPN_W];
			offset_q <= virtual_address[PO-1:0];
			mframe_q <= map_frame;
		end
	end

	// Page table: read both levels at transfer, write on map or clear.
	always_comb begin
		pg_we     = 1'b0;
		pg_waddr  = vpn_q;
		pg_wdata  = {1'b1, mframe_q};
		out_we    = 1'b0;
		out_waddr = vpn_q[INNER_INDEX_WIDTH +: OUTER_INDEX_WIDTH];
		out_wdata = 1'b1;
		if (state_q == ST_CLEAR) begin
			pg_we     = 1'b1;
			pg_waddr  = clr_q;
			pg_wdata  = '0;
			out_we    = 1'b1;
			out_waddr = clr_q[OUTER_INDEX_WIDTH-1:0];
			out_wdata = 1'b0;
		end else if (do_look && action_q == ACT_MAP) begin
			pg_we  = 1'b1;
			out_we = 1'b1;
		end
	end

	tlbw_ram #(.WIDTH(FRAME_W + 1), .DEPTH(PAGES)) u_page_ram (
		.clk   (clk),
		.we    (pg_we),
		.waddr (pg_waddr),
		.wdata (pg_wdata),
		.re    (accept),
		.raddr (virtual_address[PO +: VPN_W]),
		.rdata (pg_rdata)
	);

	tlbw_ram #(.WIDTH(1), .DEPTH(OUTERS)) u_outer_ram (
		.clk   (clk),
		.we    (out_we),
		.waddr (out_waddr),
		.wdata (out_wdata),
		.re    (accept),
		.raddr (virtual_address[PO + INNER_INDEX_WIDTH +: OUTER_INDEX_WIDTH]),
		.rdata (out_rdata)
	);

	// TLB cell chain: match and free search ripple from index 0 upward.
	assign match_c[0] = 1'b0;
	assign free_c[0]  = 1'b0;
	assign frame_c[0] = '0;
	assign age_c[0]   = '0;

	generate
		for (genvar g = 0; g < TLB_DEPTH; g++) begin : g_cell
			tlbw_cell #(.VPN_W(VPN_W), .AGE_W(AGE_W), .DEPTH(TLB_DEPTH)) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.vpn        (vpn_q),
				.fill_frame (pg_rdata[FRAME_W-1:0]),
				.ref_age    (ref_age),
				.match_in   (match_c[g]),
				.frame_in   (frame_c[g]),
				.age_in     (age_c[g]),
				.free_in    (free_c[g]),
				.match_out  (match_c[g+1]),
				.frame_out  (frame_c[g+1]),
				.age_out    (age_c[g+1]),
				.free_out   (free_c[g+1])
			);
		end
	endgenerate

	assign is_hit   = match_c[TLB_DEPTH];
	assign walk_ok  = out_rdata && pg_rdata[FRAME_W];
	assign walk_inc = out_rdata ? 2'd2 : 2'd1;

	// A fill ages every younger entry, so its reference age is the oldest.
	assign ref_age      = is_hit ? age_c[TLB_DEPTH] : AGE_W'(TLB_DEPTH - 1);
	assign ctl.upd_hit  = do_look && action_q == ACT_TRANSLATE && is_hit;
	assign ctl.upd_fill = do_look && action_q == ACT_TRANSLATE && !is_hit && walk_ok;
	assign ctl.any_free = free_c[TLB_DEPTH];

	// Result register and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid         <= 1'b0;
			hit_count         <= '0;
			miss_count        <= '0;
			walk_access_count <= '0;
		end else begin
			if (out_valid && out_ready) begin
				out_valid <= 1'b0;
			end
			if (do_look) begin
				out_valid <= 1'b1;
				if (action_q == ACT_TRANSLATE) begin
					if (is_hit) begin
						hit_count <= sat_add(hit_count, 2'd1);
					end else begin
						miss_count        <= sat_add(miss_count, 2'd1);
						walk_access_count <= sat_add(walk_access_count, walk_inc);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_look) begin
			physical_address <= '0;
			xlat_fault       <= 1'b0;
			tlb_hit          <= 1'b0;
			if (action_q == ACT_TRANSLATE) begin
				if (is_hit) begin
					physical_address <= ADDR_W'({frame_c[TLB_DEPTH], offset_q});
					tlb_hit          <= 1'b1;
				end else if (walk_ok) begin
					physical_address <= ADDR_W'({pg_rdata[FRAME_W-1:0], offset_q});
				end else begin
					xlat_fault <= 1'b1;
				end
			end
		end
	end
endmodule

// ===== sv/tlbw_checker.sv =====
// Port-level checker for the page walk MMU, bound to the top level.
// Depends on tlbw_pkg and tlb_two_level_page_walk.
`timescale 1ns / 1ps
module tlbw_checker import tlbw_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic [ADDR_W-1:0]  physical_address,
	input logic               xlat_fault,
	input logic               tlb_hit,
	input logic [CNT_W-1:0]   hit_count,
	input logic [CNT_W-1:0]   miss_count
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(physical_address))
		else $error("result dropped or changed while stalled");

	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && xlat_fault |-> physical_address == '0 && !tlb_hit)
		else $error("fault with nonzero address or hit");

	a_hit_counts: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tlb_hit |-> hit_count != '0)
		else $error("hit reported with zero hit count");

	a_mono: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> hit_count >= $past(hit_count)
			&& miss_count >= $past(miss_count))
		else $error("counter went backwards");
endmodule

bind tlb_two_level_page_walk tlbw_checker u_tlbw_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.out_valid        (out_valid),
	.out_ready        (out_ready),
	.physical_address (physical_address),
	.xlat_fault       (xlat_fault),
	.tlb_hit          (tlb_hit),
	.hit_count        (hit_count),
	.miss_count       (miss_count)
);

// ===== test/tb.sv =====
// Self-checking bench for the two-level page walk MMU with its LRU TLB.
// Depends on tlbw_pkg and tlb_two_level_page_walk; needs no files or arguments.
`timescale 1ns / 1ps
module tb;
	import tlbw_pkg::*;

	localparam int TLB_N     = TLB_DEPTH_DEF;
	localparam int VPN_W     = OUTER_W_DEF + INNER_W_DEF;
	localparam int OFF_W     = PAGE_OFFSET_DEF;
	// The clearing pass after reset keeps in_ready low while it wipes every page.
	localparam int CLEAR_CYC = 1 << VPN_W;
	localparam int WDOG_MAX  = CLEAR_CYC + 50000;
	localparam int RAND_ITEMS = 400;
	localparam int POOL_N    = 24;
	localparam int HOLD_CYC  = 300;

	typedef struct {
		logic [ADDR_W-1:0] phys;
		logic              fault;
		logic              hit;
		logic [CNT_W-1:0]  hits;
		logic [CNT_W-1:0]  misses;
		logic [CNT_W-1:0]  walks;
	} xlat_t;

	typedef struct {
		logic               act;
		logic [ADDR_W-1:0]  va;
		logic [FRAME_W-1:0] frame;
		bit                 typed;
		logic [ADDR_W-1:0]  phys;
		logic               fault;
		logic               hit;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               action = ACT_TRANSLATE;
	logic [ADDR_W-1:0]  virtual_address = '0;
	logic [FRAME_W-1:0] map_frame = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [ADDR_W-1:0]  physical_address;
	logic               xlat_fault;
	logic               tlb_hit;
	logic [CNT_W-1:0]   hit_count;
	logic [CNT_W-1:0]   miss_count;
	logic [CNT_W-1:0]   walk_access_count;

	tlb_two_level_page_walk dut (.*);

	always #5 clk = ~clk;

	// Shadow MMU state
	bit                 tv [TLB_N];
	logic [VPN_W-1:0]   tpage [TLB_N];
	logic [FRAME_W-1:0] tframe [TLB_N];
	int                 tage [TLB_N];
	bit [(1<<OUTER_W_DEF)-1:0] outer_map = '0;
	logic [FRAME_W-1:0] page_map [int];
	logic [CNT_W-1:0]   n_hits = '0, n_misses = '0, n_walks = '0;

	xlat_t pending_xlat [$];
	row_t  plan [$];
	int    errors = 0;
	int    phase = 0;
	bit    hold_req = 1'b0;
	bit    hold_done = 1'b0;
	logic [VPN_W-1:0] vpn_pool [POOL_N];

	function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	// Age every valid entry younger than old, then make entry e newest.
	function automatic void touch(input int e, input int old);
		for (int i = 0; i < TLB_N; i++)
			if (i != e && tv[i] && tage[i] < old)
				tage[i]++;
		tage[e] = 0;
	endfunction

	function automatic xlat_t mmu_predict(input logic act, input logic [ADDR_W-1:0] va,
			input logic [FRAME_W-1:0] fr);
		xlat_t r;
		logic [VPN_W-1:0] vpn;
		logic [OFF_W-1:0] off;
		int outer, victim, old;
		bit found;
		vpn = va[OFF_W +: VPN_W];
		off = va[OFF_W-1:0];
		outer = vpn >> INNER_W_DEF;
		r.phys = '0;
		r.fault = 1'b0;
		r.hit = 1'b0;
		found = 1'b0;
		if (act == ACT_MAP) begin
			outer_map[outer] = 1'b1;
			page_map[int'(vpn)] = fr;
		end else begin
			for (int i = 0; i < TLB_N && !found; i++)
				if (tv[i] && tpage[i] == vpn) begin
					found = 1'b1;
					r.phys = {tframe[i], off};
					r.hit = 1'b1;
					touch(i, tage[i]);
					n_hits = bump(n_hits);
				end
			if (!found) begin
				n_misses = bump(n_misses);
				n_walks = bump(n_walks);
				if (!outer_map[outer])
					r.fault = 1'b1;
				else begin
					n_walks = bump(n_walks);
					if (!page_map.exists(int'(vpn)))
						r.fault = 1'b1;
					else begin
						// Fill lowest free slot, else the oldest (lowest index on ties).
						victim = -1;
						for (int i = 0; i < TLB_N && victim < 0; i++)
							if (!tv[i])
								victim = i;
						if (victim >= 0)
							old = TLB_N - 1;
						else begin
							victim = 0;
							old = tage[0];
							for (int i = 1; i < TLB_N; i++)
								if (tage[i] > old) begin
									old = tage[i];
									victim = i;
								end
						end
						tv[victim] = 1'b1;
						tpage[victim] = vpn;
						tframe[victim] = page_map[int'(vpn)];
						touch(victim, old);
						r.phys = {page_map[int'(vpn)], off};
					end
				end
			end
		end
		r.hits = n_hits;
		r.misses = n_misses;
		r.walks = n_walks;
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	function automatic void add_row(input logic act, input logic [ADDR_W-1:0] va,
			input logic [FRAME_W-1:0] fr, input bit typed, input logic [ADDR_W-1:0] ph,
			input logic flt, input logic h);
		row_t r;
		r.act = act; r.va = va; r.frame = fr; r.typed = typed;
		r.phys = ph; r.fault = flt; r.hit = h;
		plan.push_back(r);
	endfunction

	// Drive one item and hold it until the transfer; returns at the accepting edge.
	task automatic send(input row_t r);
		xlat_t p;
		in_valid <= 1'b1;
		action <= r.act;
		virtual_address <= r.va;
		map_frame <= r.frame;
		do @(posedge clk); while (!in_ready);
		p = mmu_predict(r.act, r.va, r.frame);
		// Rows with a typed answer override the predictor's translation fields.
		if (r.typed) begin
			p.phys = r.phys;
			p.fault = r.fault;
			p.hit = r.hit;
		end
		pending_xlat.push_back(p);
	endtask

	// Stimulus
	initial begin
		row_t r;
		int gap, idle_pct, pick;
		for (int i = 0; i < POOL_N; i++)
			vpn_pool[i] = {10'($urandom_range(0, 4) * 205), 10'($urandom)};

		// Directed: empty tables, extremes, partial walk, stale TLB entry.
		add_row(ACT_TRANSLATE, 32'h0000_0000, '0, 1, '0, 1'b1, 1'b0);
		add_row(ACT_TRANSLATE, 32'hFFFF_FFFF, '0, 1, '0, 1'b1, 1'b0);
		add_row(ACT_MAP, 32'hFFFF_FFFF, 20'hFFFFF, 1, '0, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'hFFFF_FFFF, '0, 1, 32'hFFFF_FFFF, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'hFFFF_F000, '0, 1, 32'hFFFF_F000, 1'b0, 1'b1);
		add_row(ACT_TRANSLATE, 32'hFFFF_E000, '0, 1, '0, 1'b1, 1'b0);
		add_row(ACT_MAP, 32'h0000_0000, 20'h00000, 1, '0, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'h0000_0ABC, '0, 1, 32'h0000_0ABC, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'h0000_0FFF, '0, 1, 32'h0000_0FFF, 1'b0, 1'b1);
		add_row(ACT_MAP, 32'hFFFF_F123, 20'h12345, 1, '0, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'hFFFF_F456, '0, 1, 32'hFFFF_F456, 1'b0, 1'b1);
		add_row(ACT_MAP, 32'h5555_5555, 20'hAAAAA, 0, '0, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'h5555_5AAA, '0, 0, '0, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'h5540_0000, '0, 0, '0, 1'b0, 1'b0);
		add_row(ACT_TRANSLATE, 32'hAAAA_A000, '0, 0, '0, 1'b0, 1'b0);

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			send(plan[i]);

		for (int n = 0; n < RAND_ITEMS; n++) begin
			phase = n * 3 / RAND_ITEMS;
			if (n == RAND_ITEMS / 2)
				hold_req = 1'b1;
			idle_pct = (phase == 0) ? 10 : (phase == 1) ? 68 : 0;
			gap = 0;
			while ($urandom_range(0, 99) < idle_pct)
				gap++;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pick = $urandom_range(0, 99);
			r.act = (pick < 30) ? ACT_MAP : ACT_TRANSLATE;
			if ($urandom_range(0, 9) == 0)
				r.va = $urandom;
			else
				r.va = {vpn_pool[$urandom_range(0, POOL_N - 1)], 12'($urandom)};
			r.frame = FRAME_W'($urandom);
			r.typed = 1'b0;
			send(r);
		end
		in_valid <= 1'b0;

		while (pending_xlat.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Receiver: check each result transfer, then pick next ready.
	int hold_left = 0;
	always @(posedge clk) begin
		xlat_t w;
		int stall_pct;
		if (out_valid && out_ready) begin
			if (pending_xlat.size() == 0) begin
				report("result with nothing pending", 64'(physical_address), '0);
			end else begin
				w = pending_xlat.pop_front();
				if (physical_address !== w.phys)
					report("physical_address", 64'(physical_address), 64'(w.phys));
				if (xlat_fault !== w.fault)
					report("xlat_fault", 64'(xlat_fault), 64'(w.fault));
				if (tlb_hit !== w.hit)
					report("tlb_hit", 64'(tlb_hit), 64'(w.hit));
				if (hit_count !== w.hits)
					report("hit_count", 64'(hit_count), 64'(w.hits));
				if (miss_count !== w.misses)
					report("miss_count", 64'(miss_count), 64'(w.misses));
				if (walk_access_count !== w.walks)
					report("walk_access_count", 64'(walk_access_count), 64'(w.walks));
			end
		end
		// Hold off once for a long stretch so the block backs up into its input.
		if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYC;
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 1'b0;
		end else begin
			stall_pct = (phase == 0) ? 68 : (phase == 1) ? 10 : 0;
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Watchdog: count cycles with no transfer on either side.
	int quiet = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet <= 0;
		else if (quiet >= WDOG_MAX) begin
			$display("[FAIL] regression broken");
			$finish;
		end else
			quiet <= quiet + 1;
	end
endmodule
